/* rtl/positional_keyed_list_macros.svh */
// Assertion helpers for the keyed list.
`ifndef POSITIONAL_KEYED_LIST_MACROS_SVH
`define POSITIONAL_KEYED_LIST_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define PKL_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("keyed list check failed");
// Check a property on every clock edge, reset included.
`define PKL_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("keyed list check failed");
`else
`define PKL_ASSERT(lbl, clk, rst_n, prop)
`define PKL_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

/* rtl/pkl_pkg.sv */
package pkl_pkg;

    // What one list cell loads at the next edge.
    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_LOAD       = 2'd1,
        CELL_TAKE_LEFT  = 2'd2,
        CELL_TAKE_RIGHT = 2'd3
    } cell_op_t;

    // Request codes on req_type.
    typedef enum logic [2:0] {
        REQ_INS_FRONT = 3'd0,
        REQ_INS_END   = 3'd1,
        REQ_INS_AT    = 3'd2,
        REQ_REM_FRONT = 3'd3,
        REQ_REM_END   = 3'd4,
        REQ_REM_AT    = 3'd5,
        REQ_FIND      = 3'd6,
        REQ_UNUSED    = 3'd7
    } req_kind_t;

    // Status codes on the result beat.
    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } req_status_t;

    // Width of the count and found-position fields on the ports.
    localparam int unsigned CNT_FIELD_W = 5;

endpackage

/* rtl/pkl_cell.sv */
module pkl_cell #(
    parameter int KEY_BITS     = 32,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                    clk,
    input  pkl_pkg::cell_op_t       op,
    input  logic [KEY_BITS-1:0]     new_key,
    input  logic [PAYLOAD_BITS-1:0] new_payload,
    input  logic [KEY_BITS-1:0]     left_key,
    input  logic [PAYLOAD_BITS-1:0] left_payload,
    input  logic [KEY_BITS-1:0]     right_key,
    input  logic [PAYLOAD_BITS-1:0] right_payload,
    input  logic [KEY_BITS-1:0]     search_key,
    input  logic                    in_use,
    output logic [KEY_BITS-1:0]     key,
    output logic [PAYLOAD_BITS-1:0] payload,
    output logic                    hit
);

    logic [KEY_BITS-1:0]     key_reg;
    logic [PAYLOAD_BITS-1:0] payload_reg;

    // Load a new entry, or take the neighbor's entry when the list shifts.
    always_ff @(posedge clk)
    begin
        unique case (op)
            pkl_pkg::CELL_LOAD:
            begin
                key_reg     <= new_key;
                payload_reg <= new_payload;
            end
            pkl_pkg::CELL_TAKE_LEFT:
            begin
                key_reg     <= left_key;
                payload_reg <= left_payload;
            end
            pkl_pkg::CELL_TAKE_RIGHT:
            begin
                key_reg     <= right_key;
                payload_reg <= right_payload;
            end
            default:
            begin
                key_reg     <= key_reg;
                payload_reg <= payload_reg;
            end
        endcase
    end

    assign key     = key_reg;
    assign payload = payload_reg;
    assign hit     = in_use && (key_reg == search_key);

endmodule

/* rtl/pkl_first_hit.sv */
module pkl_first_hit #(
    parameter int DEPTH = 16,
    parameter int CNTW  = 5
) (
    input  logic [DEPTH-1:0] hit_vec,
    output logic [CNTW-1:0]  first_pos
);

    // Lowest set bit wins; report it 1-based, zero when nothing hit.
    always_comb
    begin
        first_pos = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
            begin
                first_pos = CNTW'(i + 1);
            end
        end
    end

endmodule

/* rtl/positional_keyed_list.sv */
// Ordered list of up to DEPTH key/payload entries, kept packed from position 1.
// Input channel (in_valid/in_ready) carries one request per beat: insert at
// front, end or a 1-based position, remove first, last or at a position, or
// find a key. Output channel (out_valid/out_ready) returns one result beat per
// request: status, position of the first key match, entry count, empty flag.
// Each entry lives in one cell of a row; inserts shift cells up, removes shift
// them down, and every cell compares its key against the request in the same
// cycle, so the list is updated at the edge that accepts the beat.
// The result passes the pending stage, which captures the per-cell match bits,
// then the output register, which takes the first match.
// Throughput: one request per cycle unless the output stalls; the cell row
// does the whole update at the accepting edge and the match pick sits in the
// stage after it. A stalled receiver holds the output beat; one more request
// is accepted into the pending stage, then in_ready drops until the output moves.
// Reset clears the count, so the list comes up empty; cell contents are not
// cleared and are never read before being written.
// An insert into a full list is refused with status full; a remove from an
// empty list reports status empty. Both leave the list unchanged.
`include "positional_keyed_list_macros.svh"

module positional_keyed_list #(
    parameter int DEPTH        = 16,
    parameter int KEY_BITS     = 32,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         req_type,
    input  logic signed [31:0] entry_key,
    input  logic [31:0]        entry_payload,
    input  logic signed [6:0]  position,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic [4:0]         found_position,
    output logic [4:0]         entry_count,
    output logic               is_empty
);

    localparam int IDXW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);
    localparam int CMPW = ((CNTW > 7) ? CNTW : 7) + 1;
    localparam int FW   = pkl_pkg::CNT_FIELD_W;

    // Count of live entries.
    logic [CNTW-1:0] cnt_reg, cnt_next;

    // Pending stage: holds the request's outcome and the cells' match bits.
    logic             pend_reg, pend_next;
    logic [1:0]       pstat_reg;
    logic [CNTW-1:0]  pcnt_reg;
    logic             pfind_reg;
    logic [DEPTH-1:0] phit_reg;

    // Output register.
    logic             out_valid_reg, out_valid_next;
    logic [1:0]       ostat_reg;
    logic [CNTW-1:0]  ofound_reg;
    logic [CNTW-1:0]  ocnt_reg;

    logic in_fire, out_free, pend_move;

    // Request decode.
    logic                      list_full, list_empty;
    logic                      do_ins, do_rem;
    logic [IDXW-1:0]           op_idx;
    logic [1:0]                req_stat;
    logic                      req_find;
    logic signed [CMPW-1:0]    pos_s, cnt_s;

    // Cell row wiring.
    pkl_pkg::cell_op_t         cell_op  [DEPTH];
    logic [KEY_BITS-1:0]       cell_key [DEPTH];
    logic [PAYLOAD_BITS-1:0]   cell_pay [DEPTH];
    logic [DEPTH-1:0]          cell_use;
    logic [DEPTH-1:0]          cell_hit;
    logic [KEY_BITS-1:0]       req_key;
    logic [PAYLOAD_BITS-1:0]   req_payload;

    logic [CNTW-1:0]           first_pos;
    logic [CNTW+FW-1:0]        found_wide, cnt_wide;

    assign out_free  = !out_valid_reg || out_ready;
    assign pend_move = pend_reg && out_free;
    assign in_ready  = !pend_reg || out_free;
    assign in_fire   = in_valid && in_ready;

    assign req_key     = entry_key[KEY_BITS-1:0];
    assign req_payload = entry_payload[PAYLOAD_BITS-1:0];

    assign list_full  = (cnt_reg == CNTW'(DEPTH));
    assign list_empty = (cnt_reg == '0);
    assign pos_s      = {{(CMPW-7){position[6]}}, position};
    assign cnt_s      = {{(CMPW-CNTW){1'b0}}, cnt_reg};

    // Turn the request into one shift direction and one cell index.
    always_comb
    begin
        do_ins   = 1'b0;
        do_rem   = 1'b0;
        op_idx   = '0;
        req_stat = pkl_pkg::STAT_DONE;
        req_find = 1'b0;
        unique case (req_type)
            pkl_pkg::REQ_INS_FRONT, pkl_pkg::REQ_INS_END, pkl_pkg::REQ_INS_AT:
            begin
                if (list_full)
                begin
                    req_stat = pkl_pkg::STAT_FULL;
                end
                else
                begin
                    do_ins = 1'b1;
                    if (req_type == pkl_pkg::REQ_INS_FRONT)
                    begin
                        op_idx = '0;
                    end
                    else if (req_type == pkl_pkg::REQ_INS_END)
                    begin
                        op_idx = IDXW'(cnt_reg);
                    end
                    else if (pos_s < 2)
                    begin
                        op_idx = '0;
                    end
                    else if (pos_s >= cnt_s + 1)
                    begin
                        op_idx = IDXW'(cnt_reg);
                    end
                    else
                    begin
                        op_idx = IDXW'(pos_s - 1);
                    end
                end
            end
            pkl_pkg::REQ_REM_FRONT, pkl_pkg::REQ_REM_END, pkl_pkg::REQ_REM_AT:
            begin
                if (list_empty)
                begin
                    req_stat = pkl_pkg::STAT_EMPTY;
                end
                else
                begin
                    do_rem = 1'b1;
                    if (req_type == pkl_pkg::REQ_REM_FRONT)
                    begin
                        op_idx = '0;
                    end
                    else if (req_type == pkl_pkg::REQ_REM_END)
                    begin
                        op_idx = IDXW'(cnt_reg - 1'b1);
                    end
                    else if (pos_s < 2)
                    begin
                        op_idx = '0;
                    end
                    else if (pos_s >= cnt_s)
                    begin
                        op_idx = IDXW'(cnt_reg - 1'b1);
                    end
                    else
                    begin
                        op_idx = IDXW'(pos_s - 1);
                    end
                end
            end
            pkl_pkg::REQ_FIND:
            begin
                req_find = 1'b1;
            end
            default:
            begin
                // Unused code: change nothing, report done.
                req_stat = pkl_pkg::STAT_DONE;
            end
        endcase
    end

    // Per-cell command: above the insert point take from below, at it load;
    // from the remove point up take from above.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            cell_op[i]  = pkl_pkg::CELL_HOLD;
            cell_use[i] = (CNTW'(i) < cnt_reg);
            if (in_fire && do_ins)
            begin
                if (IDXW'(i) == op_idx)
                begin
                    cell_op[i] = pkl_pkg::CELL_LOAD;
                end
                else if (IDXW'(i) > op_idx)
                begin
                    cell_op[i] = pkl_pkg::CELL_TAKE_LEFT;
                end
            end
            else if (in_fire && do_rem)
            begin
                if (IDXW'(i) >= op_idx)
                begin
                    cell_op[i] = pkl_pkg::CELL_TAKE_RIGHT;
                end
            end
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (in_fire && do_ins)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (in_fire && do_rem)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic [KEY_BITS-1:0]     lkey, rkey;
            logic [PAYLOAD_BITS-1:0] lpay, rpay;

            if (g == 0)
            begin : g_first
                assign lkey = req_key;
                assign lpay = req_payload;
            end
            else
            begin : g_mid_l
                assign lkey = cell_key[g-1];
                assign lpay = cell_pay[g-1];
            end

            if (g == DEPTH - 1)
            begin : g_last
                assign rkey = cell_key[g];
                assign rpay = cell_pay[g];
            end
            else
            begin : g_mid_r
                assign rkey = cell_key[g+1];
                assign rpay = cell_pay[g+1];
            end

            pkl_cell #(
                .KEY_BITS     (KEY_BITS),
                .PAYLOAD_BITS (PAYLOAD_BITS)
            ) u_cell (
                .clk           (clk),
                .op            (cell_op[g]),
                .new_key       (req_key),
                .new_payload   (req_payload),
                .left_key      (lkey),
                .left_payload  (lpay),
                .right_key     (rkey),
                .right_payload (rpay),
                .search_key    (req_key),
                .in_use        (cell_use[g]),
                .key           (cell_key[g]),
                .payload       (cell_pay[g]),
                .hit           (cell_hit[g])
            );
        end
    endgenerate

    pkl_first_hit #(
        .DEPTH (DEPTH),
        .CNTW  (CNTW)
    ) u_first_hit (
        .hit_vec   (phit_reg),
        .first_pos (first_pos)
    );

    always_comb
    begin
        pend_next = pend_reg;
        if (in_fire)
        begin
            pend_next = 1'b1;
        end
        else if (pend_move)
        begin
            pend_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pend_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the beat's outcome and match bits; advance to the output.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pstat_reg <= req_stat;
            pcnt_reg  <= cnt_next;
            pfind_reg <= req_find;
            phit_reg  <= cell_hit;
        end
        if (pend_move)
        begin
            ostat_reg  <= pstat_reg;
            ofound_reg <= pfind_reg ? first_pos : '0;
            ocnt_reg   <= pcnt_reg;
        end
    end

    assign found_wide = {{FW{1'b0}}, ofound_reg};
    assign cnt_wide   = {{FW{1'b0}}, ocnt_reg};

    assign out_valid      = out_valid_reg;
    assign status         = ostat_reg;
    assign found_position = found_wide[FW-1:0];
    assign entry_count    = cnt_wide[FW-1:0];
    assign is_empty       = (ocnt_reg == '0);

    // Count never passes capacity; it is unknown only while reset is held.
    `PKL_ASSERT_ALWAYS(a_cnt_bound, clk, !rst_n || cnt_reg <= CNTW'(DEPTH))
    // Count moves only on an accepted beat.
    `PKL_ASSERT(a_cnt_quiet, clk, rst_n, !in_fire |=> $stable(cnt_reg))
    // An accepted beat moves the count by at most one.
    `PKL_ASSERT(a_cnt_step, clk, rst_n, in_fire |=> (cnt_reg == $past(cnt_reg) || cnt_reg == $past(cnt_reg) + 1 || cnt_reg + 1 == $past(cnt_reg)))
    // A reported match lies inside the list.
    `PKL_ASSERT(a_found_in_list, clk, rst_n, (out_valid_reg && ofound_reg != '0) |-> (ofound_reg <= ocnt_reg && ostat_reg == pkl_pkg::STAT_DONE))

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;

    localparam int LIST_DEPTH    = 16;
    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 8;

    // Receiver behavior, changed after each random span.
    typedef enum logic [1:0] {
        READY_ALWAYS  = 2'd0,
        READY_COIN    = 2'd1,
        READY_SPARSE  = 2'd2,
        READY_PATTERN = 2'd3
    } stall_mode_t;

    typedef struct packed {
        pkl_pkg::req_status_t            status;
        logic [pkl_pkg::CNT_FIELD_W-1:0] found;
        logic [pkl_pkg::CNT_FIELD_W-1:0] count;
        logic                            empty;
    } list_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [2:0]         req_type = '0;
    logic signed [31:0] entry_key = '0;
    logic [31:0]        entry_payload = '0;
    logic signed [6:0]  position = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         status;
    logic [4:0]         found_position;
    logic [4:0]         entry_count;
    logic               is_empty;

    // Shadow copy of the list contents, kept packed from index 0.
    logic [31:0]  shadow_key [LIST_DEPTH];
    logic [31:0]  shadow_payload [LIST_DEPTH];
    int           shadow_fill = 0;

    // Results owed by the block, oldest first.
    list_result_t pending_results[$];

    int           error_count = 0;
    int           idle_cycles = 0;
    int           burst_left = 0;

    stall_mode_t  stall_mode = READY_ALWAYS;
    int           stall_span = 0;
    logic [7:0]   stall_bits = 8'hFF;

    positional_keyed_list DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .entry_key      (entry_key),
        .entry_payload  (entry_payload),
        .position       (position),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .found_position (found_position),
        .entry_count    (entry_count),
        .is_empty       (is_empty)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one request to the shadow list and return the result it owes.
    function automatic list_result_t update_list_shadow(pkl_pkg::req_kind_t req,
                                                        logic [31:0] key,
                                                        logic [31:0] payload,
                                                        logic signed [6:0] pos);
        list_result_t res;
        int           p;
        int           idx;
        bit           hit;
        res = '0;
        p   = int'(pos);
        idx = 0;
        hit = 1'b0;
        case (req)
            pkl_pkg::REQ_INS_FRONT, pkl_pkg::REQ_INS_END, pkl_pkg::REQ_INS_AT:
            begin
                if (shadow_fill >= LIST_DEPTH)
                begin
                    res.status = pkl_pkg::STAT_FULL;
                end
                else
                begin
                    // Clamp the position: low goes to the front, past the end appends.
                    if (req == pkl_pkg::REQ_INS_FRONT)
                        idx = 0;
                    else if (req == pkl_pkg::REQ_INS_END)
                        idx = shadow_fill;
                    else if (p <= 1)
                        idx = 0;
                    else if (p >= shadow_fill + 1)
                        idx = shadow_fill;
                    else
                        idx = p - 1;
                    for (int i = shadow_fill; i > idx; i--)
                    begin
                        shadow_key[i]     = shadow_key[i-1];
                        shadow_payload[i] = shadow_payload[i-1];
                    end
                    shadow_key[idx]     = key;
                    shadow_payload[idx] = payload;
                    shadow_fill++;
                end
            end
            pkl_pkg::REQ_REM_FRONT, pkl_pkg::REQ_REM_END, pkl_pkg::REQ_REM_AT:
            begin
                if (shadow_fill == 0)
                begin
                    res.status = pkl_pkg::STAT_EMPTY;
                end
                else
                begin
                    // Clamp the position: low takes the first, at or past the count the last.
                    if (req == pkl_pkg::REQ_REM_FRONT)
                        idx = 0;
                    else if (req == pkl_pkg::REQ_REM_END)
                        idx = shadow_fill - 1;
                    else if (p <= 1)
                        idx = 0;
                    else if (p >= shadow_fill)
                        idx = shadow_fill - 1;
                    else
                        idx = p - 1;
                    for (int i = idx; i + 1 < shadow_fill; i++)
                    begin
                        shadow_key[i]     = shadow_key[i+1];
                        shadow_payload[i] = shadow_payload[i+1];
                    end
                    shadow_fill--;
                end
            end
            pkl_pkg::REQ_FIND:
            begin
                for (int i = 0; i < shadow_fill; i++)
                begin
                    if (!hit && shadow_key[i] == key)
                    begin
                        res.found = pkl_pkg::CNT_FIELD_W'(i + 1);
                        hit       = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        res.count = pkl_pkg::CNT_FIELD_W'(shadow_fill);
        res.empty = (shadow_fill == 0);
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: mismatch on %s, got %0d expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // Send one request beat. Called just after a rising edge; returns at the
    // edge that accepts the beat, with valid still high.
    task automatic send_request(pkl_pkg::req_kind_t req, logic [31:0] key,
                                logic [31:0] payload, logic signed [6:0] pos);
        int gap;
        // Start a new burst, opening with a random gap (possibly none).
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_valid      <= 1'b1;
        req_type      <= req;
        entry_key     <= key;
        entry_payload <= payload;
        position      <= pos;
        // Hold the beat until the block takes it.
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        burst_left--;
        pending_results.push_back(update_list_shadow(req, key, payload, pos));
    endtask

    // Drop valid and wait for every owed result to come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // Every remove, a find and the unused code on a freshly reset, empty list.
    task automatic test_empty_list();
        send_request(pkl_pkg::REQ_REM_FRONT, 32'h0, 32'h0, 7'sd0);
        send_request(pkl_pkg::REQ_REM_END, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'sd1);
        send_request(pkl_pkg::REQ_REM_AT, 32'h0, 32'h0, 7'sd5);
        send_request(pkl_pkg::REQ_FIND, 32'h0, 32'h0, 7'sd0);
        send_request(pkl_pkg::REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, -7'sd1);
        drain_results();
    endtask

    // Clamped and in-range positions for insert and remove, key extremes,
    // a duplicate key and finds that hit first, hit later and miss.
    task automatic test_positions();
        send_request(pkl_pkg::REQ_INS_AT, 32'h8000_0000, 32'h0000_0000, -7'sd64);
        send_request(pkl_pkg::REQ_INS_END, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 7'sd0);
        send_request(pkl_pkg::REQ_INS_AT, 32'h0000_0000, 32'hA5A5_A5A5, 7'sd63);
        send_request(pkl_pkg::REQ_INS_AT, 32'hFFFF_FFFF, 32'h5A5A_5A5A, 7'sd2);
        send_request(pkl_pkg::REQ_INS_AT, 32'h0000_0005, 32'h0000_0001, 7'sd1);
        send_request(pkl_pkg::REQ_INS_FRONT, 32'h0000_0000, 32'h8000_0000, 7'sd0);
        send_request(pkl_pkg::REQ_FIND, 32'h0000_0000, 32'h0, 7'sd0);
        send_request(pkl_pkg::REQ_FIND, 32'h7FFF_FFFF, 32'h0, 7'sd0);
        send_request(pkl_pkg::REQ_FIND, 32'h1234_5678, 32'h0, 7'sd0);
        send_request(pkl_pkg::REQ_REM_AT, 32'h0, 32'h0, -7'sd64);
        send_request(pkl_pkg::REQ_REM_AT, 32'h0, 32'h0, 7'sd63);
        send_request(pkl_pkg::REQ_REM_AT, 32'h0, 32'h0, 7'sd2);
        send_request(pkl_pkg::REQ_REM_END, 32'h0, 32'h0, 7'sd0);
        send_request(pkl_pkg::REQ_FIND, 32'h0000_0000, 32'h0, 7'sd0);
        drain_results();
    endtask

    // Fill to capacity, try every insert kind on a full list, find the entry
    // at the top position, then remove at the count and at the front.
    task automatic test_full_list();
        logic [31:0] top_key;
        top_key = 32'h1000_0000;
        while (shadow_fill < LIST_DEPTH)
        begin
            top_key = 32'h1000_0000 + shadow_fill;
            send_request(pkl_pkg::REQ_INS_END, top_key, $urandom, 7'sd0);
        end
        send_request(pkl_pkg::REQ_INS_FRONT, 32'hDEAD_0001, 32'h1, 7'sd0);
        send_request(pkl_pkg::REQ_INS_END, 32'hDEAD_0002, 32'h2, 7'sd0);
        send_request(pkl_pkg::REQ_INS_AT, 32'hDEAD_0003, 32'h3, 7'sd8);
        send_request(pkl_pkg::REQ_FIND, top_key, 32'h0, 7'sd0);
        send_request(pkl_pkg::REQ_REM_AT, 32'h0, 32'h0, 7'sd16);
        send_request(pkl_pkg::REQ_REM_FRONT, 32'h0, 32'h0, 7'sd0);
        drain_results();
    endtask

    // One random request; grow_pct sets the share of inserts so the list
    // drifts toward full or toward empty.
    task automatic send_random_request(int grow_pct);
        pkl_pkg::req_kind_t req;
        logic [31:0]        key;
        logic signed [6:0]  pos;
        int                 roll;
        roll = $urandom_range(0, 99);
        if (roll < 2)
            req = pkl_pkg::REQ_UNUSED;
        else if (roll < 14)
            req = pkl_pkg::REQ_FIND;
        else if (roll < 14 + grow_pct)
            req = pkl_pkg::req_kind_t'($urandom_range(0, 2));
        else
            req = pkl_pkg::req_kind_t'($urandom_range(3, 5));
        // Mix keys already held, a small pool that makes duplicates, and noise.
        roll = $urandom_range(0, 2);
        if (roll == 0 && shadow_fill > 0)
            key = shadow_key[$urandom_range(0, shadow_fill - 1)];
        else if (roll == 1)
            key = 32'($urandom_range(0, 5)) - 32'd2;
        else
            key = $urandom;
        if ($urandom_range(0, 1) == 0)
            pos = 7'($urandom_range(0, shadow_fill + 2));
        else
            pos = 7'($urandom);
        send_request(req, key, $urandom, pos);
    endtask

    // Alternate rounds that drive the list toward full, toward empty, and
    // hover in between.
    task automatic test_random_traffic();
        for (int round = 0; round < 6; round++)
        begin
            for (int n = 0; n < 150; n++)
                send_random_request(round % 3 == 0 ? 62 : (round % 3 == 1 ? 22 : 43));
        end
        drain_results();
    endtask

    initial
    begin
        // Hold reset at the start, then release it and run the tests in turn.
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_list();
        test_positions();
        test_full_list();
        test_random_traffic();
        // Let any stray beat show up before the verdict.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    // Receiver: pick a stall style for a random span, then follow it.
    always @(posedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_mode <= stall_mode_t'($urandom_range(0, 3));
            stall_span <= $urandom_range(16, 96);
            stall_bits <= 8'($urandom);
            out_ready  <= 1'b1;
        end
        else
        begin
            stall_span <= stall_span - 1;
            case (stall_mode)
                READY_ALWAYS:  out_ready <= 1'b1;
                READY_COIN:    out_ready <= 1'($urandom_range(0, 1));
                READY_SPARSE:  out_ready <= ($urandom_range(0, 3) == 0);
                default:
                begin
                    // Rotate a fixed eight-bit pattern so the stalls repeat.
                    out_ready  <= stall_bits[0];
                    stall_bits <= {stall_bits[0], stall_bits[7:1]};
                end
            endcase
        end
    end

    // Check each result beat against the oldest owed result.
    always @(posedge clk)
    begin : check_results
        list_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result beat", 32'(entry_count), 32'd0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                    report_mismatch("status", 32'(status), 32'(want.status));
                if (found_position !== want.found)
                    report_mismatch("found_position", 32'(found_position), 32'(want.found));
                if (entry_count !== want.count)
                    report_mismatch("entry_count", 32'(entry_count), 32'(want.count));
                if (is_empty !== want.empty)
                    report_mismatch("is_empty", 32'(is_empty), 32'(want.empty));
            end
        end
    end

    // Watchdog: end the run if no beat moves on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
                $display("tb NOT OK");
                $finish;
            end
        end
    end

endmodule
